// ----- hw/rtl/pair_matrix_next_pending_scan_core_assert.svh -----
// Assertion macros for the pair matrix scan core.
`ifndef PAIR_MATRIX_NEXT_PENDING_SCAN_CORE_ASSERT_SVH
`define PAIR_MATRIX_NEXT_PENDING_SCAN_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PMNPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmnps assertion failed");

// Next-cycle implication, checked out of reset.
`define PMNPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmnps assertion failed");

`endif

// ----- hw/rtl/pmnps_pkg.sv -----
// Package with constants, types and helpers for the pair matrix scan core.
package pmnps_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned ROWS      = 64;
  localparam int unsigned ROW_W     = 64;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CNT_W     = 7;

  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_SET   = 2'd1,
    OP_FETCH = 2'd2
  } op_t;

  typedef struct packed {
    logic             rejected;
    logic [IDX_W-1:0] pair_to;
    logic [IDX_W-1:0] pair_from;
    logic             found;
  } res_t;

  // Lowest set bit of a row.
  function automatic logic [IDX_W-1:0] lowest_bit(input logic [ROW_W-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- hw/rtl/pair_matrix_next_pending_scan_core.sv -----
// Pair matrix next-pending scan core: upper-triangular pending bit matrix with a fetch cursor.
//
// Timing: one item at a time. The pending matrix sits in a 64x64 RAM with one
// read and one write port. Set reads then writes back the addressed row,
// mark-all reads then writes back each tracked row, and fetch scans the rows in
// turn, the scan being limited by the single RAM read port. Op code 3 goes
// straight to the result word. The next item is taken only once the result word
// is loaded. A finished word waits in the output register while the next item is
// already accepted; a second finished word holds until the first one is taken.
// Rows never written read as zero through per-row valid bits, so no clearing
// pass follows reset.
`include "pair_matrix_next_pending_scan_core_assert.svh"

module pair_matrix_next_pending_scan_core
  import pmnps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // index_from[5:0], index_to[11:6], zero pad
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pair_from[5:0], pair_to[11:6], zero pad
  output logic [1:0]  out_tuser,  // found[0], rejected[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // items_in_use
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MRD  = 7'b0000010,
    ST_MWR  = 7'b0000100,
    ST_SRD  = 7'b0001000,
    ST_SWR  = 7'b0010000,
    ST_SCAN = 7'b0100000,
    ST_RESP = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_row_r, chk_row_nxt;
  logic             first_r, first_nxt;
  logic             chk_first_r, chk_first_nxt;
  logic [IDX_W-1:0] from_r, from_nxt;
  logic [IDX_W-1:0] to_r, to_nxt;
  logic [IDX_W-1:0] cur_row_r, cur_row_nxt;
  logic [IDX_W-1:0] cur_col_r, cur_col_nxt;
  res_t             res_r, res_nxt;
  res_t             out_r, out_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [ROWS-1:0]  vld_r;
  logic [IDX_W-1:0] raddr_q_r;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  logic [ROW_W-1:0] row_eff, cmask, above, cand;
  logic [IDX_W-1:0] hit_col;
  logic             hit, rd_en, in_acc;
  logic [IDX_W-1:0] in_from, in_to;
  logic [1:0]       in_op;

  pmnps_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_op      = in_tuser;
  assign in_from    = in_tdata[5:0];
  assign in_to      = in_tdata[11:6];
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_r.pair_to, out_r.pair_from};
  assign out_tuser  = {out_r.rejected, out_r.found};

  assign row_eff = vld_r[raddr_q_r] ? ram_rdata : '0;
  assign cmask   = (ROW_W'(1) << cnt_r) - ROW_W'(1);
  assign above   = ~ROW_W'(0) << (CNT_W'(cur_col_r) + CNT_W'(1));
  assign cand    = row_eff & cmask & (chk_first_r ? above : ~ROW_W'(0));
  assign hit     = (state_r == ST_SCAN) && chk_vld_r && (cand != '0);
  assign hit_col = lowest_bit(cand);
  assign rd_en   = (row_r < cnt_r);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    chk_vld_nxt   = chk_vld_r;
    chk_row_nxt   = chk_row_r;
    first_nxt     = first_r;
    chk_first_nxt = chk_first_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    ram_we        = 1'b0;
    ram_waddr     = row_r[IDX_W-1:0];
    ram_wdata     = row_eff;
    ram_re        = 1'b0;
    ram_raddr     = row_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt  = '0;
          from_nxt = in_from;
          to_nxt   = in_to;
          row_nxt  = '0;
          case (in_op)
            OP_MARK: begin
              state_nxt = (cnt_r == '0) ? ST_RESP : ST_MRD;
            end
            OP_SET: begin
              if (in_from >= in_to || CNT_W'(in_to) >= cnt_r) begin
                res_nxt.rejected = 1'b1;
                state_nxt        = ST_RESP;
              end else begin
                state_nxt = ST_SRD;
              end
            end
            OP_FETCH: begin
              first_nxt   = (cur_row_r != '0) || (cur_col_r != '0);
              row_nxt     = CNT_W'(cur_row_r);
              chk_vld_nxt = 1'b0;
              state_nxt   = ST_SCAN;
            end
            default: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_MRD: begin
        ram_re    = 1'b1;
        state_nxt = ST_MWR;
      end
      ST_MWR: begin
        ram_we    = 1'b1;
        ram_wdata = row_eff | (cmask & (~ROW_W'(0) << (row_r + CNT_W'(1))));
        row_nxt   = row_r + CNT_W'(1);
        state_nxt = (row_r + CNT_W'(1) >= cnt_r) ? ST_RESP : ST_MRD;
      end
      ST_SRD: begin
        ram_re    = 1'b1;
        ram_raddr = from_r;
        state_nxt = ST_SWR;
      end
      ST_SWR: begin
        ram_we    = 1'b1;
        ram_waddr = from_r;
        ram_wdata = row_eff | (ROW_W'(1) << to_r);
        state_nxt = ST_RESP;
      end
      ST_SCAN: begin
        if (hit) begin
          ram_we            = 1'b1;
          ram_waddr         = chk_row_r;
          ram_wdata         = row_eff & ~(ROW_W'(1) << hit_col);
          cur_row_nxt       = chk_row_r;
          cur_col_nxt       = hit_col;
          res_nxt.found     = 1'b1;
          res_nxt.pair_from = chk_row_r;
          res_nxt.pair_to   = hit_col;
          chk_vld_nxt       = 1'b0;
          state_nxt         = ST_RESP;
        end else if (!rd_en && !chk_vld_r) begin
          state_nxt = ST_RESP;
        end else begin
          ram_re        = rd_en;
          chk_vld_nxt   = rd_en;
          chk_row_nxt   = row_r[IDX_W-1:0];
          chk_first_nxt = first_r;
          first_nxt     = 1'b0;
          row_nxt       = rd_en ? row_r + CNT_W'(1) : row_r;
        end
      end
      ST_RESP: begin
        if (!out_vld_r || out_tready) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= CNT_W'(MAX_ITEMS);
      chk_vld_r <= 1'b0;
      first_r   <= 1'b0;
      cur_row_r <= '0;
      cur_col_r <= '0;
      out_vld_r <= 1'b0;
      vld_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= chk_vld_nxt;
      first_r   <= first_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      out_vld_r <= out_vld_nxt;
      if (ram_we) vld_r[ram_waddr] <= 1'b1;
      if (cfg_valid && cfg_ready) begin
        cnt_r <= (cfg_data > CNT_W'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS) : cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    chk_row_r   <= chk_row_nxt;
    chk_first_r <= chk_first_nxt;
    from_r      <= from_nxt;
    to_r        <= to_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
    if (ram_re) raddr_q_r <= ram_raddr;
  end

  `PMNPS_ASSERT_IMP(a_found_not_rejected, out_vld_r, !(out_r.found && out_r.rejected))
  `PMNPS_ASSERT_IMP(a_found_ordered, out_vld_r && out_r.found,
                    out_r.pair_from < out_r.pair_to)
  `PMNPS_ASSERT_IMP(a_no_rw_same_cycle, ram_we, !ram_re)
  `PMNPS_ASSERT_NXT(a_one_item, in_acc, !in_tready)

endmodule

// ----- hw/rtl/pmnps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pmnps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- test/tb.sv -----
// Self-checking bench for the pair matrix scan core: mark, set and fetch traffic.
`timescale 1ns / 1ps

module tb
  import pmnps_pkg::*;
();

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int END_WAIT = 200;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx_from;
    logic [IDX_W-1:0] idx_to;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  word_t word_q[$];
  res_t  result_q[$];

  logic [ROW_W-1:0] pend_bits[ROWS];
  logic [IDX_W-1:0] scan_row = '0;
  logic [IDX_W-1:0] scan_col = '0;
  logic [CNT_W-1:0] item_limit = 7'd64;

  int words_added = 0;
  int words_taken = 0;
  int results_seen = 0;
  int pairs_found = 0;
  int sets_refused = 0;
  int count_writes = 0;
  int fail_count = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  int quiet_cycles = 0;

  pair_matrix_next_pending_scan_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < ROWS; i++) pend_bits[i] = '0;
  end

  // Advance the pair matrix by one word and return the result it yields.
  function automatic res_t apply_word(input logic [1:0] code, input logic [IDX_W-1:0] a,
                                      input logic [IDX_W-1:0] b);
    res_t r;
    int lim;
    int row;
    int col;
    int first;
    logic [ROW_W-1:0] live;
    logic [ROW_W-1:0] bits;
    r = '0;
    row = -1;
    col = 0;
    first = 0;
    bits = '0;
    lim = (item_limit > 7'd64) ? 64 : int'(item_limit);
    live = (lim >= 64) ? '1 : ((64'd1 << lim) - 64'd1);
    case (code)
      OP_MARK: begin
        for (int k = 0; k < lim; k++)
          pend_bits[k] = pend_bits[k] | (live & ~((64'd1 << (k + 1)) - 64'd1));
      end
      OP_SET: begin
        if (a >= b || int'(b) >= lim) r.rejected = 1'b1;
        else pend_bits[a][b] = 1'b1;
      end
      OP_FETCH: begin
        if (scan_row != 0 || scan_col != 0) begin
          first = int'(scan_row) + 1;
          if (int'(scan_row) < lim && scan_col != 6'd63)
            bits = pend_bits[scan_row] & live & ({64{1'b1}} << (int'(scan_col) + 1));
          if (bits != 0) row = int'(scan_row);
        end
        for (int k = first; k < lim && row < 0; k++) begin
          bits = pend_bits[k] & live;
          if (bits != 0) row = k;
        end
        if (row >= 0) begin
          while (!bits[col]) col++;
          pend_bits[row][col] = 1'b0;
          scan_row = IDX_W'(row);
          scan_col = IDX_W'(col);
          r.found = 1'b1;
          r.pair_from = IDX_W'(row);
          r.pair_to = IDX_W'(col);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : drive_p
    word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (word_q.size() != 0) begin
        w = word_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {4'b0, w.idx_to, w.idx_from};
        in_tuser <= w.op;
        if ($urandom_range(0, 99) < in_idle_pct) in_gap = $urandom_range(1, 10);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_p
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        want = apply_word(in_tuser, in_tdata[5:0], in_tdata[11:6]);
        result_q.push_back(want);
        words_taken++;
        if (want.found) pairs_found++;
        if (want.rejected) sets_refused++;
      end
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing expected: tdata %h tuser %h", out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          results_seen++;
          if (out_tuser[0] !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_tuser[0]);
            fail_count++;
          end
          if (out_tdata[5:0] !== want.pair_from) begin
            $error("pair_from: expected %0d, got %0d", want.pair_from, out_tdata[5:0]);
            fail_count++;
          end
          if (out_tdata[11:6] !== want.pair_to) begin
            $error("pair_to: expected %0d, got %0d", want.pair_to, out_tdata[11:6]);
            fail_count++;
          end
          if (out_tuser[1] !== want.rejected) begin
            $error("rejected: expected %0d, got %0d", want.rejected, out_tuser[1]);
            fail_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(0, 63));
  endfunction

  task automatic add_word(input logic [1:0] code, input logic [IDX_W-1:0] a,
                          input logic [IDX_W-1:0] b);
    word_t w;
    w.op = code;
    w.idx_from = a;
    w.idx_to = b;
    word_q.push_back(w);
    words_added++;
  endtask

  // Hold until every word is taken and every result has come back.
  task automatic settle();
    do @(posedge clk);
    while (words_added != words_taken || result_q.size() != 0);
  endtask

  task automatic load_count(input logic [CNT_W-1:0] v);
    settle();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    item_limit = v;
    count_writes++;
  endtask

  initial begin
    int n;
    int p;
    int lim;
    int row;
    int col;
    logic [CNT_W-1:0] cnt;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 20;
    out_idle_pct = 20;

    add_word(OP_FETCH, 6'd0, 6'd0);
    add_word(OP_NONE, 6'd63, 6'd63);
    add_word(OP_SET, 6'd63, 6'd0);
    add_word(OP_SET, 6'd9, 6'd9);
    add_word(OP_SET, 6'd0, 6'd63);
    add_word(OP_SET, 6'd0, 6'd1);
    add_word(OP_SET, 6'd3, 6'd4);
    add_word(OP_FETCH, 6'd0, 6'd0);
    add_word(OP_SET, 6'd0, 6'd1);
    add_word(OP_FETCH, 6'd63, 6'd63);
    add_word(OP_FETCH, 6'd0, 6'd0);
    add_word(OP_FETCH, 6'd0, 6'd0);
    add_word(OP_SET, 6'd3, 6'd40);
    load_count(7'd2);
    add_word(OP_MARK, 6'd0, 6'd0);
    add_word(OP_SET, 6'd0, 6'd1);
    add_word(OP_SET, 6'd1, 6'd2);
    add_word(OP_FETCH, 6'd0, 6'd0);
    load_count(7'd5);
    add_word(OP_FETCH, 6'd0, 6'd0);
    load_count(7'd1);
    add_word(OP_MARK, 6'd0, 6'd0);
    add_word(OP_SET, 6'd0, 6'd1);
    add_word(OP_FETCH, 6'd0, 6'd0);
    load_count(7'd0);
    add_word(OP_SET, 6'd0, 6'd0);
    load_count(7'd127);
    add_word(OP_SET, 6'd3, 6'd63);
    add_word(OP_FETCH, 6'd0, 6'd0);
    add_word(OP_FETCH, 6'd0, 6'd0);

    while (words_added < 1300) begin
      settle();
      if (words_added > 1150) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = 20 * $urandom_range(0, 2);
        out_idle_pct = 20 * $urandom_range(0, 2);
      end
      p = $urandom_range(0, 99);
      if (p < 55) cnt = 7'd64;
      else if (p < 75) cnt = CNT_W'($urandom_range((scan_row > 62) ? 64 : scan_row + 2, 64));
      else if (p < 83) cnt = CNT_W'($urandom_range(65, 127));
      else if (p < 90) cnt = CNT_W'($urandom_range(0, 2));
      else cnt = CNT_W'($urandom_range(0, scan_row));
      load_count(cnt);
      lim = (cnt > 7'd64) ? 64 : int'(cnt);
      n = $urandom_range(15, 40);
      if ($urandom_range(0, 2) != 0) add_word(OP_MARK, any_index(), any_index());
      for (int k = 0; k < n; k++) begin
        if (k == n / 2 && $urandom_range(0, 3) == 0) settle();
        p = $urandom_range(0, 99);
        if (p < 55) begin
          add_word(OP_FETCH, any_index(), any_index());
        end else if (p < 88 && lim >= 2) begin
          if (p < 80) begin
            row = int'(scan_row) + $urandom_range(0, 2);
            if (row > lim - 2) row = lim - 2;
          end else begin
            row = $urandom_range(0, lim - 2);
          end
          col = $urandom_range(row + 1, lim - 1);
          add_word(OP_SET, IDX_W'(row), IDX_W'(col));
        end else if (p < 96) begin
          add_word(OP_SET, any_index(), any_index());
        end else if (p < 98) begin
          add_word(OP_NONE, any_index(), any_index());
        end else begin
          add_word(OP_MARK, any_index(), any_index());
        end
      end
    end

    load_count(7'd64);
    add_word(OP_SET, 6'd62, 6'd63);
    add_word(OP_FETCH, 6'd0, 6'd0);
    add_word(OP_FETCH, 6'd0, 6'd0);
    add_word(OP_SET, 6'd61, 6'd62);
    add_word(OP_FETCH, 6'd0, 6'd0);
    load_count(7'd2);
    add_word(OP_FETCH, 6'd0, 6'd0);

    settle();
    repeat (END_WAIT) @(posedge clk);
    if (result_q.size() != 0) $error("%0d results never arrived", result_q.size());
    $display("covered %0d words under %0d item-count settings, %0d results checked",
             words_taken, count_writes, results_seen);
    $display("%0d pairs returned, %0d set requests refused, cursor ended at (%0d,%0d)",
             pairs_found, sets_refused, scan_row, scan_col);
    if (fail_count == 0 && result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
